/* hdl/rau_pkg.sv */
// shared constants for the rational arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;
  localparam int NUM_BITS = 32;
  localparam int PW = 64;
  localparam int CW = $clog2(PW);
  localparam logic [PW-1:0] RES_LIM = ({{(PW-1){1'b0}}, 1'b1} << (NUM_BITS - 1)) - 1'b1;

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_CMP = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIVZERO  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
endpackage
`default_nettype wire

/* hdl/rational_arithmetic_unit_top.sv */
// top level of the rational arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
// Exact add, subtract, multiply, divide and compare of two rationals, result in
// lowest terms. A beat is taken when start_i is high and busy_o is low; the
// result shows for one cycle with valid_o high and cannot be held off. Invalid
// operations and zero divisors answer in the cycle after the beat, a compare after
// the M0, M1, M2 and SUM states. Other operations make three passes through one
// 32x32 multiplier, a binary gcd loop over the 64-bit cross products, and two
// 64-step restoring divides by the gcd.
module rational_arithmetic_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] x_num_i,
  input  logic [30:0] x_den_i,
  input  logic [31:0] y_num_i,
  input  logic [30:0] y_den_i,
  output logic        valid_o,
  output logic [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic [1:0]  order_o,
  output logic [1:0]  status_o
);
  import rau_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M0   = 3'd1;
  localparam logic [2:0] S_M1   = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_ABS  = 3'd5;
  localparam logic [2:0] S_RED  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [2:0]    func_q, func_d;
  logic          sx_q, sx_d, sy_q, sy_d, neg_q, neg_d;
  logic [31:0]   xm_q, xm_d, ym_q, ym_d;
  logic [30:0]   xd_q, xd_d, yd_q, yd_d;
  logic [PW-1:0] a_q, a_d, b_q, b_d, d_q, d_d, u_q, u_d, v_q, v_d;
  logic          valid_q, valid_d;
  logic [31:0]   num_q, num_d;
  logic [30:0]   den_q, den_d;
  logic [1:0]    ord_q, ord_d, st_q, st_d;

  logic [31:0]   mul_a, mul_b;
  logic [PW-1:0] prod, sa, sb, sum, um;
  logic          red_go, red_done;
  logic [PW-1:0] red_mag, red_den;

  assign prod = PW'(mul_a) * PW'(mul_b);
  assign sa   = sx_q ? -a_q : a_q;
  assign sb   = (sy_q ^ (func_q == FUNC_SUB)) ? -b_q : b_q;
  assign sum  = sa + sb;
  assign um   = u_q[PW-1] ? -u_q : u_q;

  always_comb begin
    case (state_q)
      S_M0: begin
        mul_a = xm_q;
        mul_b = (func_q == FUNC_MUL) ? ym_q : {1'b0, yd_q};
      end
      S_M1: begin
        mul_a = {1'b0, xd_q};
        mul_b = ym_q;
      end
      default: begin
        mul_a = {1'b0, xd_q};
        mul_b = {1'b0, yd_q};
      end
    endcase
  end

  assign red_go = (state_q == S_ABS) && (um != '0);

  rau_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (red_go),
    .mag_i  (um),
    .den_i  (v_q),
    .done_o (red_done),
    .mag_o  (red_mag),
    .den_o  (red_den)
  );

  always_comb begin
    state_d = state_q;
    func_d = func_q;
    sx_d = sx_q;
    sy_d = sy_q;
    neg_d = neg_q;
    xm_d = xm_q;
    ym_d = ym_q;
    xd_d = xd_q;
    yd_d = yd_q;
    a_d = a_q;
    b_d = b_q;
    d_d = d_q;
    u_d = u_q;
    v_d = v_q;
    valid_d = 1'b0;
    num_d = num_q;
    den_d = den_q;
    ord_d = ord_q;
    st_d = st_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d = func_i;
          sx_d = x_num_i[31];
          sy_d = y_num_i[31];
          xm_d = x_num_i[31] ? -x_num_i : x_num_i;
          ym_d = y_num_i[31] ? -y_num_i : y_num_i;
          xd_d = x_den_i;
          yd_d = y_den_i;
          num_d = '0;
          den_d = '0;
          ord_d = '0;
          if (func_i > FUNC_CMP) begin
            valid_d = 1'b1;
            st_d = ST_OK;
          end else if (x_den_i == '0 || y_den_i == '0 ||
                       (func_i == FUNC_DIV && y_num_i == '0)) begin
            valid_d = 1'b1;
            st_d = ST_DIVZERO;
          end else begin
            state_d = S_M0;
          end
        end
      end
      S_M0: begin
        a_d = prod;
        state_d = S_M1;
      end
      S_M1: begin
        b_d = prod;
        state_d = S_M2;
      end
      S_M2: begin
        d_d = prod;
        state_d = S_SUM;
      end
      S_SUM: begin
        if (func_q == FUNC_CMP) begin
          valid_d = 1'b1;
          st_d = ST_OK;
          num_d = '0;
          den_d = '0;
          if ($signed(sa) > $signed(sb)) begin
            ord_d = 2'b01;
          end else if ($signed(sa) < $signed(sb)) begin
            ord_d = 2'b11;
          end else begin
            ord_d = 2'b00;
          end
          state_d = S_IDLE;
        end else begin
          if (func_q == FUNC_ADD || func_q == FUNC_SUB) begin
            u_d = sum;
            neg_d = sum[PW-1];
          end else begin
            u_d = a_q;
            neg_d = sx_q ^ sy_q;
          end
          v_d = (func_q == FUNC_DIV) ? b_q : d_q;
          state_d = S_ABS;
        end
      end
      S_ABS: begin
        if (um == '0) begin
          valid_d = 1'b1;
          st_d = ST_OK;
          num_d = '0;
          den_d = 31'd1;
          ord_d = '0;
          state_d = S_IDLE;
        end else begin
          state_d = S_RED;
        end
      end
      S_RED: begin
        if (red_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        valid_d = 1'b1;
        ord_d = '0;
        if (red_den > RES_LIM || red_mag > RES_LIM + PW'(neg_q)) begin
          st_d = ST_OVERFLOW;
          num_d = '0;
          den_d = '0;
        end else begin
          st_d = ST_OK;
          num_d = neg_q ? -red_mag[31:0] : red_mag[31:0];
          den_d = red_den[30:0];
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    sx_q <= sx_d;
    sy_q <= sy_d;
    neg_q <= neg_d;
    xm_q <= xm_d;
    ym_q <= ym_d;
    xd_q <= xd_d;
    yd_q <= yd_d;
    a_q <= a_d;
    b_q <= b_d;
    d_q <= d_d;
    u_q <= u_d;
    v_q <= v_d;
    num_q <= num_d;
    den_q <= den_d;
    ord_q <= ord_d;
    st_q <= st_d;
  end

  assign busy_o    = (state_q != S_IDLE);
  assign valid_o   = valid_q;
  assign res_num_o = num_q;
  assign res_den_o = den_q;
  assign order_o   = ord_q;
  assign status_o  = st_q;
endmodule
`default_nettype wire

/* hdl/rau_reduce.sv */
// binary gcd and restoring divider that bring a fraction to lowest terms
`timescale 1ns / 1ps
`default_nettype none
module rau_reduce (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    go_i,
  input  logic [rau_pkg::PW-1:0]  mag_i,
  input  logic [rau_pkg::PW-1:0]  den_i,
  output logic                    done_o,
  output logic [rau_pkg::PW-1:0]  mag_o,
  output logic [rau_pkg::PW-1:0]  den_o
);
  import rau_pkg::*;

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_GCD  = 2'd1;
  localparam logic [1:0] R_DIVN = 2'd2;
  localparam logic [1:0] R_DIVD = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [PW-1:0] u_q, u_d, v_q, v_d, g_q, g_d;
  logic [PW-1:0] mag_q, mag_d, den_q, den_d, dvd_q, dvd_d, rem_q, rem_d;
  logic [CW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [PW:0]   trial;
  logic [PW:0]   trial_sub;
  logic          ge;

  assign trial     = {rem_q, dvd_q[PW-1]};
  assign ge        = trial >= {1'b0, g_q};
  assign trial_sub = trial - {1'b0, g_q};

  always_comb begin
    state_d = state_q;
    u_d = u_q;
    v_d = v_q;
    g_d = g_q;
    k_d = k_q;
    mag_d = mag_q;
    den_d = den_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    case (state_q)
      R_IDLE: begin
        if (go_i) begin
          u_d = mag_i;
          v_d = den_i;
          mag_d = mag_i;
          den_d = den_i;
          k_d = '0;
          state_d = R_GCD;
        end
      end
      R_GCD: begin
        if (u_q == v_q) begin
          g_d = u_q << k_q;
          dvd_d = mag_q;
          rem_d = '0;
          cnt_d = '0;
          state_d = R_DIVN;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q > v_q) begin
          u_d = (u_q - v_q) >> 1;
        end else begin
          v_d = (v_q - u_q) >> 1;
        end
      end
      R_DIVN, R_DIVD: begin
        rem_d = ge ? trial_sub[PW-1:0] : trial[PW-1:0];
        dvd_d = {dvd_q[PW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(PW - 1)) begin
          rem_d = '0;
          cnt_d = '0;
          if (state_q == R_DIVN) begin
            mag_d = {dvd_q[PW-2:0], ge};
            dvd_d = den_q;
            state_d = R_DIVD;
          end else begin
            den_d = {dvd_q[PW-2:0], ge};
            done_d = 1'b1;
            state_d = R_IDLE;
          end
        end
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    v_q <= v_d;
    g_q <= g_d;
    k_q <= k_d;
    mag_q <= mag_d;
    den_q <= den_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign mag_o  = mag_q;
  assign den_o  = den_q;
endmodule
`default_nettype wire
